FILE: sv/mcta_pkg.sv
// Shared types and constants for the media clock timestamp alignment check.
// No dependencies; used by the divider cells, the grid check and the top level.
package mcta_pkg;

  localparam int unsigned StampW  = 32;
  localparam int unsigned PeriodW = 48;
  localparam int unsigned TimeW   = 64;

  // Per-beat flags that travel alongside the arithmetic
  typedef struct packed {
    logic checked;
    logic video_valid;
    logic pres_valid;
  } side_t;

endpackage

FILE: sv/mcta_div_cell.sv
// One restoring-division step for both timestamp lanes, with its own beat register.
// Depends on mcta_pkg. Chained by the top level, one cell per numerator bit.
module mcta_div_cell #(
  parameter int unsigned NW   = 49,
  parameter int unsigned RW   = 50,
  parameter int unsigned STEP = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic                         adv_i,
  output logic                         adv_o,
  output logic                         valid_o,
  input  logic [mcta_pkg::PeriodW-1:0] p_i,
  output logic [mcta_pkg::PeriodW-1:0] p_o,
  input  mcta_pkg::side_t              side_i,
  output mcta_pkg::side_t              side_o,
  input  logic [mcta_pkg::StampW-1:0]  d_v_i,
  output logic [mcta_pkg::StampW-1:0]  d_v_o,
  input  logic [mcta_pkg::StampW-1:0]  d_p_i,
  output logic [mcta_pkg::StampW-1:0]  d_p_o,
  input  logic [NW-1:0]                n_v_i,
  output logic [NW-1:0]                n_v_o,
  input  logic [NW-1:0]                n_p_i,
  output logic [NW-1:0]                n_p_o,
  input  logic [RW-1:0]                r_v_i,
  output logic [RW-1:0]                r_v_o,
  input  logic [RW-1:0]                r_p_i,
  output logic [RW-1:0]                r_p_o
);

  localparam int unsigned BitIdx = NW - 1 - STEP;

  logic                         valid_q;
  logic [mcta_pkg::PeriodW-1:0] p_q;
  mcta_pkg::side_t              side_q;
  logic [mcta_pkg::StampW-1:0]  d_v_q, d_p_q;
  logic [NW-1:0]                n_v_q, n_p_q;
  logic [RW-1:0]                r_v_q, r_p_q, r_v_d, r_p_d;
  logic [RW-1:0]                div, s_v, s_p;

  // divisor is twice the period
  assign div = RW'({p_i, 1'b0});
  assign s_v = {r_v_i[RW-2:0], n_v_i[BitIdx]};
  assign s_p = {r_p_i[RW-2:0], n_p_i[BitIdx]};

  always_comb begin
    r_v_d = (s_v >= div) ? (s_v - div) : s_v;
    r_p_d = (s_p >= div) ? (s_p - div) : s_p;
  end

  assign adv_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      p_q    <= p_i;
      side_q <= side_i;
      d_v_q  <= d_v_i;
      d_p_q  <= d_p_i;
      n_v_q  <= n_v_i;
      n_p_q  <= n_p_i;
      r_v_q  <= r_v_d;
      r_p_q  <= r_p_d;
    end
  end

  assign valid_o = valid_q;
  assign p_o     = p_q;
  assign side_o  = side_q;
  assign d_v_o   = d_v_q;
  assign d_p_o   = d_p_q;
  assign n_v_o   = n_v_q;
  assign n_p_o   = n_p_q;
  assign r_v_o   = r_v_q;
  assign r_p_o   = r_p_q;

endmodule

FILE: sv/mcta_grid.sv
// Grid point rounding, quarter-period distance test and result flags; two stages.
// Depends on mcta_pkg. Fed by the last divider cell, drives the result port.
module mcta_grid #(
  parameter int unsigned NW = 49,
  parameter int unsigned RW = 50,
  parameter int unsigned F  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         adv_o,
  input  logic                         stall_i,
  output logic                         valid_o,
  input  logic                         drop_en_i,
  input  logic [mcta_pkg::PeriodW-1:0] p_i,
  input  mcta_pkg::side_t              side_i,
  input  logic [mcta_pkg::StampW-1:0]  d_v_i,
  input  logic [mcta_pkg::StampW-1:0]  d_p_i,
  input  logic [NW-1:0]                n_v_i,
  input  logic [NW-1:0]                n_p_i,
  input  logic [RW-1:0]                r_v_i,
  input  logic [RW-1:0]                r_p_i,
  output logic                         checked_o,
  output logic                         video_mismatch_o,
  output logic                         pres_mismatch_o,
  output logic                         drop_o
);

  localparam logic [NW-1:0] Half = (F > 0) ? NW'(1) << ((F + NW - 1) % NW) : '0;
  localparam int unsigned   Sh   = F + 2;

  logic                         a_valid_q, b_valid_q, adv_a, adv_b;
  logic [mcta_pkg::PeriodW-1:0] p_q;
  mcta_pkg::side_t              side_q;
  logic [mcta_pkg::StampW-1:0]  d_v_q, d_p_q;
  logic [NW-1:0]                gi_v_q, gi_p_q, gi_v_d, gi_p_d;
  logic [NW-1:0]                dist_v, dist_p;
  logic                         off_v, off_p, vm, pm, drop_v;
  logic                         checked_q, vm_q, pm_q, drop_q;

  // n*P equals (N - r) / 2, so no multiplier is needed
  always_comb begin
    gi_v_d = (((n_v_i - NW'(r_v_i)) >> 1) + Half) >> F;
    gi_p_d = (((n_p_i - NW'(r_p_i)) >> 1) + Half) >> F;
  end

  always_comb begin
    dist_v = (gi_v_q >= NW'(d_v_q)) ? (gi_v_q - NW'(d_v_q)) : (NW'(d_v_q) - gi_v_q);
    dist_p = (gi_p_q >= NW'(d_p_q)) ? (gi_p_q - NW'(d_p_q)) : (NW'(d_p_q) - gi_p_q);
    off_v  = ((64'(dist_v) << Sh) > 64'(p_q));
    off_p  = ((64'(dist_p) << Sh) > 64'(p_q));
    vm     = side_q.checked && side_q.video_valid && off_v;
    drop_v = vm && drop_en_i;
    // presentation check is skipped once the video check has dropped the beat
    pm     = side_q.checked && side_q.pres_valid && !drop_v && off_p;
  end

  assign adv_b = !b_valid_q || !stall_i;
  assign adv_a = !a_valid_q || adv_b;
  assign adv_o = adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_q <= valid_i;
      end
      if (adv_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      p_q    <= p_i;
      side_q <= side_i;
      d_v_q  <= d_v_i;
      d_p_q  <= d_p_i;
      gi_v_q <= gi_v_d;
      gi_p_q <= gi_p_d;
    end
    if (adv_b) begin
      checked_q <= side_q.checked;
      vm_q      <= vm;
      pm_q      <= pm;
      drop_q    <= drop_v || (pm && drop_en_i);
    end
  end

  assign valid_o          = b_valid_q;
  assign checked_o        = checked_q;
  assign video_mismatch_o = vm_q;
  assign pres_mismatch_o  = pm_q;
  assign drop_o           = drop_q;

endmodule

FILE: sv/media_clock_timestamp_alignment_check_unit.sv
// Top level of the media clock timestamp alignment check.
// Depends on mcta_pkg, mcta_div_cell and mcta_grid.
//
// Checks a packet's presentation and video timestamps against the reference
// media clock grid and flags or drops packets that are off by more than a
// quarter period. One beat is taken per clock cycle while stall_o is low, and
// results leave in order. A row of restoring-division cells, one per bit of
// the division numerator (NW bits, 50 at 16 fraction bits), lies between
// the front stage and the grid check. Stalls on the result side hold the
// row back only as far as it is full.
module media_clock_timestamp_alignment_check_unit #(
  parameter int unsigned PERIOD_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] ref_time_i,
  input  logic [47:0] ref_period_q16_i,
  input  logic        packet_ok_i,
  input  logic        pres_valid_i,
  input  logic [31:0] pres_stamp_i,
  input  logic        video_valid_i,
  input  logic [31:0] video_stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        checked_o,
  output logic        video_mismatch_o,
  output logic        pres_mismatch_o,
  output logic        drop_o
);

  localparam int unsigned F  = PERIOD_FRAC_BITS;
  localparam int unsigned PW = mcta_pkg::PeriodW;
  localparam int unsigned SW = mcta_pkg::StampW;
  localparam int unsigned DW = SW + F;
  localparam int unsigned NW = ((DW + 1 > PW) ? DW + 1 : PW) + 1;
  localparam int unsigned RW = PW + 2;

  logic drop_en_q;

  // register file: one register, any address in the word selects it
  assign pready = 1'b1;
  assign prdata = {31'b0, drop_en_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      drop_en_q <= pwdata[0];
    end
  end

  // front stage: offset from reference and division numerator 2D + P
  logic            f_valid_q, f_adv;
  logic [PW-1:0]   f_p_q;
  mcta_pkg::side_t f_side_q, f_side_d;
  logic [SW-1:0]   f_dv_q, f_dp_q, f_dv_d, f_dp_d;
  logic [NW-1:0]   f_nv_q, f_np_q;

  logic            c_valid [NW];
  logic            c_adv   [NW];
  logic [PW-1:0]   c_p     [NW];
  mcta_pkg::side_t c_side  [NW];
  logic [SW-1:0]   c_dv    [NW];
  logic [SW-1:0]   c_dp    [NW];
  logic [NW-1:0]   c_nv    [NW];
  logic [NW-1:0]   c_np    [NW];
  logic [RW-1:0]   c_rv    [NW];
  logic [RW-1:0]   c_rp    [NW];
  logic            g_adv;

  // extension to 64 bits leaves the low word difference unchanged
  always_comb begin
    f_dv_d = video_stamp_i - ref_time_i[SW-1:0];
    f_dp_d = pres_stamp_i - ref_time_i[SW-1:0];
    f_side_d.checked     = packet_ok_i && (ref_period_q16_i != '0) && (ref_time_i != '0);
    f_side_d.video_valid = video_valid_i;
    f_side_d.pres_valid  = pres_valid_i;
  end

  assign f_adv   = !f_valid_q || c_adv[0];
  assign stall_o = !f_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (f_adv) begin
      f_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_adv) begin
      f_p_q    <= ref_period_q16_i;
      f_side_q <= f_side_d;
      f_dv_q   <= f_dv_d;
      f_dp_q   <= f_dp_d;
      f_nv_q   <= (NW'(f_dv_d) << (F + 1)) + NW'(ref_period_q16_i);
      f_np_q   <= (NW'(f_dp_d) << (F + 1)) + NW'(ref_period_q16_i);
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_cell
    logic            vin;
    logic            ain;
    logic [PW-1:0]   pin;
    mcta_pkg::side_t sin;
    logic [SW-1:0]   dvin, dpin;
    logic [NW-1:0]   nvin, npin;
    logic [RW-1:0]   rvin, rpin;

    if (k == 0) begin : g_first
      assign vin  = f_valid_q;
      assign pin  = f_p_q;
      assign sin  = f_side_q;
      assign dvin = f_dv_q;
      assign dpin = f_dp_q;
      assign nvin = f_nv_q;
      assign npin = f_np_q;
      assign rvin = '0;
      assign rpin = '0;
    end else begin : g_rest
      assign vin  = c_valid[k-1];
      assign pin  = c_p[k-1];
      assign sin  = c_side[k-1];
      assign dvin = c_dv[k-1];
      assign dpin = c_dp[k-1];
      assign nvin = c_nv[k-1];
      assign npin = c_np[k-1];
      assign rvin = c_rv[k-1];
      assign rpin = c_rp[k-1];
    end

    if (k == NW - 1) begin : g_last
      assign ain = g_adv;
    end else begin : g_mid
      assign ain = c_adv[k+1];
    end

    mcta_div_cell #(
      .NW  (NW),
      .RW  (RW),
      .STEP(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vin),
      .adv_i  (ain),
      .adv_o  (c_adv[k]),
      .valid_o(c_valid[k]),
      .p_i    (pin),
      .p_o    (c_p[k]),
      .side_i (sin),
      .side_o (c_side[k]),
      .d_v_i  (dvin),
      .d_v_o  (c_dv[k]),
      .d_p_i  (dpin),
      .d_p_o  (c_dp[k]),
      .n_v_i  (nvin),
      .n_v_o  (c_nv[k]),
      .n_p_i  (npin),
      .n_p_o  (c_np[k]),
      .r_v_i  (rvin),
      .r_v_o  (c_rv[k]),
      .r_p_i  (rpin),
      .r_p_o  (c_rp[k])
    );
  end

  mcta_grid #(
    .NW(NW),
    .RW(RW),
    .F (F)
  ) u_grid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (c_valid[NW-1]),
    .adv_o           (g_adv),
    .stall_i         (out_stall_i),
    .valid_o         (out_valid_o),
    .drop_en_i       (drop_en_q),
    .p_i             (c_p[NW-1]),
    .side_i          (c_side[NW-1]),
    .d_v_i           (c_dv[NW-1]),
    .d_p_i           (c_dp[NW-1]),
    .n_v_i           (c_nv[NW-1]),
    .n_p_i           (c_np[NW-1]),
    .r_v_i           (c_rv[NW-1]),
    .r_p_i           (c_rp[NW-1]),
    .checked_o       (checked_o),
    .video_mismatch_o(video_mismatch_o),
    .pres_mismatch_o (pres_mismatch_o),
    .drop_o          (drop_o)
  );

endmodule
